// ===== rtl/spq_pkg.sv =====
// Shared definitions for the sorted priority queue: request and status codes,
// the cell control bundle, the state encoding and the default parameter values.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 8;
    localparam int TAG_BITS_DEF  = 16;

    // Width of the request kind field.
    localparam int OP_W = 3;

    // Request kinds; codes five to seven are undefined and report not found.
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK      = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND_EQ   = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_GE   = 3'd4;

    // Result status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NONE = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    // Control bundle that the top level sends to every cell.
    typedef struct packed {
        logic            cmp_en;     // latch compare flags for a new request
        logic            ins_en;     // shift toward the tail and place the new entry
        logic            rem_en;     // close the gap left by the removed entry
        logic [OP_W-1:0] op;         // request kind seen at compare time
        logic            match_tag;  // remove also needs tag equality
    } cell_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue: holds a priority and a tag, compares them to
// the request and moves data to or from its neighbors. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell #(
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic                  aclk,
    input  spq_pkg::cell_ctl_t    ctl,
    input  logic                  occupied,    // slot index is below the fill count
    input  logic [PRIO_BITS-1:0]  key,
    input  logic [TAG_BITS-1:0]   key_tag,
    input  logic [PRIO_BITS-1:0]  left_prio,
    input  logic [TAG_BITS-1:0]   left_tag,
    input  logic                  left_gt,
    input  logic [PRIO_BITS-1:0]  right_prio,
    input  logic [TAG_BITS-1:0]   right_tag,
    input  logic                  hit_at_or_before,
    output logic [PRIO_BITS-1:0]  prio_o,
    output logic [TAG_BITS-1:0]   tag_o,
    output logic                  hit_o,
    output logic                  gt_o
);
    import spq_pkg::*;

    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic                 hit_reg, hit_next;
    logic                 gt_reg, gt_next;

    logic eq_key, gt_key, ge_key, tag_eq;

    // Local compares against the request key.
    assign eq_key = (prio_reg == key);
    assign gt_key = (prio_reg > key);
    assign ge_key = eq_key || gt_key;
    assign tag_eq = (tag_reg == key_tag);

    // Compare flags, taken when a request is accepted.
    always_comb begin
        hit_next = hit_reg;
        gt_next  = gt_reg;
        if (ctl.cmp_en) begin
            // An empty slot counts as greater, so an insert lands at the tail.
            gt_next = !occupied || gt_key;
            case (ctl.op)
                OP_REMOVE:  hit_next = occupied && eq_key && (!ctl.match_tag || tag_eq);
                OP_PEEK:    hit_next = occupied;
                OP_FIND_EQ: hit_next = occupied && eq_key;
                OP_FIND_GE: hit_next = occupied && ge_key;
                default:    hit_next = 1'b0;
            endcase
        end
    end

    // Slot contents move one place on insert or remove.
    always_comb begin
        prio_next = prio_reg;
        tag_next  = tag_reg;
        if (ctl.ins_en) begin
            if (left_gt) begin
                prio_next = left_prio;
                tag_next  = left_tag;
            end else if (gt_reg) begin
                prio_next = key;
                tag_next  = key_tag;
            end
        end else if (ctl.rem_en && hit_at_or_before) begin
            prio_next = right_prio;
            tag_next  = right_tag;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
        hit_reg  <= hit_next;
        gt_reg   <= gt_next;
    end

    assign prio_o = prio_reg;
    assign tag_o  = tag_reg;
    assign hit_o  = hit_reg;
    assign gt_o   = gt_reg;

endmodule

// ===== rtl/spq_prefix.sv =====
// Prefix OR over the cell hit flags, in log2(DEPTH) doubling steps; gives the
// first hit as a one-hot vector and the at-or-before mask. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_prefix #(
    parameter int DEPTH = 16
) (
    input  logic [DEPTH-1:0] hit,
    output logic [DEPTH-1:0] incl,
    output logic [DEPTH-1:0] first,
    output logic             any
);
    import spq_pkg::*;

    localparam int LV = $clog2(DEPTH);

    logic [DEPTH-1:0] lvl [0:LV];

    assign lvl[0] = hit;

    // Each step folds in the flags 2^k places toward the head.
    for (genvar k = 0; k < LV; k++) begin : g_step
        for (genvar i = 0; i < DEPTH; i++) begin : g_bit
            if (i >= (1 << k)) begin : g_or
                assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
            end else begin : g_pass
                assign lvl[k+1][i] = lvl[k][i];
            end
        end
    end

    assign incl = lvl[LV];

    // The first hit is a hit with none before it.
    for (genvar i = 0; i < DEPTH; i++) begin : g_first
        if (i == 0) begin : g_head
            assign first[i] = hit[i];
        end else begin : g_rest
            assign first[i] = hit[i] & ~incl[i-1];
        end
    end

    assign any = incl[DEPTH-1];

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: stream ports, request sequencer,
// the row of cells and the result register. Depends on spq_pkg, spq_cell
// and spq_prefix.
`timescale 1ns / 1ps

// The queue holds up to DEPTH entries of priority and tag in ascending order
// of priority, older first among equals, in a row of cells that each compare
// in parallel and pass data to their neighbors. In the cycle a request beat
// is accepted every cell latches its compare flags; then, in the update
// state, a prefix OR picks the first matching cell, the row shifts for
// insert or remove and the result goes to the output register. The input
// side is ready again only when the update is done, so no new request is
// taken while one is in flight; when the output register still holds an
// untaken result the update waits for it.
// Request kinds: 0 insert, 1 remove, 2 peek head, 3 find equal, 4 find at
// least; status 0 is success, 1 not found or empty, 2 full.
module sorted_priority_queue_unit #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
    parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int S_DW     = ((PRIO_BITS + TAG_BITS + 7) / 8) * 8,
    localparam int M_DW     = ((PRIO_BITS + TAG_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    // s_tdata: priority_req, tag (from bit 0 up), zero padded
    input  logic [S_DW-1:0] s_tdata,
    // s_tuser: req_type [2:0], match_tag [3]
    input  logic [3:0]      s_tuser,
    input  logic            s_tvalid,
    output logic            s_tready,
    // m_tdata: result_priority, result_tag, entry_count (from bit 0 up), zero padded
    output logic [M_DW-1:0] m_tdata,
    // m_tuser: status
    output logic [1:0]      m_tuser,
    output logic            m_tvalid,
    input  logic            m_tready
);
    import spq_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [OP_W-1:0]       op_reg;
    logic [PRIO_BITS-1:0]  key_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [PRIO_BITS-1:0]  out_prio_reg, out_prio_next;
    logic [TAG_BITS-1:0]   out_tag_reg, out_tag_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;

    logic                  accept;
    logic                  apply_fire;
    logic                  full;
    cell_ctl_t             ctl;
    logic [PRIO_BITS-1:0]  key_mux;
    logic [TAG_BITS-1:0]   tag_mux;

    logic [PRIO_BITS-1:0]  cell_prio [DEPTH];
    logic [TAG_BITS-1:0]   cell_tag  [DEPTH];
    logic [DEPTH-1:0]      cell_hit;
    logic [DEPTH-1:0]      cell_gt;
    logic [DEPTH-1:0]      hit_incl;
    logic [DEPTH-1:0]      hit_first;
    logic                  hit_any;
    logic [PRIO_BITS-1:0]  sel_prio;
    logic [TAG_BITS-1:0]   sel_tag;

    // Handshake and sequencing.
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign apply_fire = (state_reg == S_APPLY) && (!out_valid_reg || m_tready);
    assign full       = (count_reg == CNT_W'(DEPTH));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_APPLY;
            S_APPLY: if (apply_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Request register, loaded with the accepted beat.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_tuser[OP_W-1:0];
            key_reg <= s_tdata[PRIO_BITS-1:0];
            tag_reg <= s_tdata[PRIO_BITS +: TAG_BITS];
        end
    end

    // The cells compare against the port in the accept cycle, and take the
    // stored request as the new entry in the update cycle.
    assign key_mux = (state_reg == S_APPLY) ? key_reg : s_tdata[PRIO_BITS-1:0];
    assign tag_mux = (state_reg == S_APPLY) ? tag_reg : s_tdata[PRIO_BITS +: TAG_BITS];

    always_comb begin
        ctl.cmp_en    = accept;
        ctl.ins_en    = apply_fire && (op_reg == OP_INSERT) && !full;
        ctl.rem_en    = apply_fire && (op_reg == OP_REMOVE) && hit_any;
        ctl.op        = s_tuser[OP_W-1:0];
        ctl.match_tag = s_tuser[OP_W];
    end

    // The row of cells, head at index 0.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [PRIO_BITS-1:0] l_prio, r_prio;
        logic [TAG_BITS-1:0]  l_tag, r_tag;
        logic                 l_gt;

        if (i == 0) begin : g_left_end
            assign l_prio = cell_prio[i];
            assign l_tag  = cell_tag[i];
            assign l_gt   = 1'b0;
        end else begin : g_left
            assign l_prio = cell_prio[i-1];
            assign l_tag  = cell_tag[i-1];
            assign l_gt   = cell_gt[i-1];
        end

        if (i == DEPTH - 1) begin : g_right_end
            assign r_prio = cell_prio[i];
            assign r_tag  = cell_tag[i];
        end else begin : g_right
            assign r_prio = cell_prio[i+1];
            assign r_tag  = cell_tag[i+1];
        end

        spq_cell #(
            .PRIO_BITS (PRIO_BITS),
            .TAG_BITS  (TAG_BITS)
        ) u_cell (
            .aclk             (aclk),
            .ctl              (ctl),
            .occupied         (CNT_W'(i) < count_reg),
            .key              (key_mux),
            .key_tag          (tag_mux),
            .left_prio        (l_prio),
            .left_tag         (l_tag),
            .left_gt          (l_gt),
            .right_prio       (r_prio),
            .right_tag        (r_tag),
            .hit_at_or_before (hit_incl[i]),
            .prio_o           (cell_prio[i]),
            .tag_o            (cell_tag[i]),
            .hit_o            (cell_hit[i]),
            .gt_o             (cell_gt[i])
        );
    end

    // First matching cell.
    spq_prefix #(
        .DEPTH (DEPTH)
    ) u_prefix (
        .hit   (cell_hit),
        .incl  (hit_incl),
        .first (hit_first),
        .any   (hit_any)
    );

    // One-hot select of the first matching entry.
    always_comb begin
        sel_prio = '0;
        sel_tag  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_prio = sel_prio | (cell_prio[i] & {PRIO_BITS{hit_first[i]}});
            sel_tag  = sel_tag  | (cell_tag[i]  & {TAG_BITS{hit_first[i]}});
        end
    end

    // Result and fill count for the request in the update cycle.
    always_comb begin
        out_status_next = STAT_NONE;
        out_prio_next   = '0;
        out_tag_next    = '0;
        count_next      = count_reg;
        case (op_reg)
            OP_INSERT: begin
                if (full) begin
                    out_status_next = STAT_FULL;
                end else begin
                    out_status_next = STAT_OK;
                    out_prio_next   = key_reg;
                    out_tag_next    = tag_reg;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (hit_any) begin
                    out_status_next = STAT_OK;
                    out_prio_next   = sel_prio;
                    out_tag_next    = sel_tag;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            OP_PEEK, OP_FIND_EQ, OP_FIND_GE: begin
                if (hit_any) begin
                    out_status_next = STAT_OK;
                    out_prio_next   = sel_prio;
                    out_tag_next    = sel_tag;
                end
            end
            default: out_status_next = STAT_NONE;
        endcase
        out_count_next = count_next;
    end

    // Output register valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (apply_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (apply_fire) begin
                count_reg <= count_next;
            end
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (apply_fire) begin
            out_status_reg <= out_status_next;
            out_prio_reg   <= out_prio_next;
            out_tag_reg    <= out_tag_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_DW'({out_count_reg, out_tag_reg, out_prio_reg});

`ifndef NO_ASSERTIONS
    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count exceeds depth");

    // An accepted beat is always followed by its update cycle.
    a_accept_to_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_APPLY))
        else $error("accepted request did not reach the update cycle");

    // The fill count moves only in an update cycle.
    a_count_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |-> $past(apply_fire))
        else $error("fill count changed outside an update cycle");

    // At most one cell is picked as the first match.
    a_first_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY) |-> $onehot0(hit_first))
        else $error("more than one first match");

    // A full status is reported only with the queue at its depth.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_status_reg == STAT_FULL)) |-> (out_count_reg == CNT_W'(DEPTH)))
        else $error("full status with room left");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the sorted priority queue top level.
// Depends on spq_pkg and sorted_priority_queue_unit; a local queue predictor
// computes every expected result, and a monitor compares them beat by beat.
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int QDEPTH  = 16;
    localparam int S_DW    = 24;
    localparam int M_DW    = 32;
    localparam int CLK_PER = 12;

    // Request codes above find-at-least are undefined.
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  prio;
        logic [15:0] tag;
        logic [4:0]  count;
    } queue_result_t;

    logic            aclk     = 1'b0;
    logic            aresetn  = 1'b0;
    logic [S_DW-1:0] s_tdata  = '0;
    logic [3:0]      s_tuser  = '0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [M_DW-1:0] m_tdata;
    logic [1:0]      m_tuser;
    logic            m_tvalid;
    logic            m_tready = 1'b0;

    // Shadow copy of the queue contents.
    logic [7:0]  shadow_prio[QDEPTH];
    logic [15:0] shadow_tag[QDEPTH];
    int          shadow_count = 0;

    queue_result_t pending_results[$];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int n_requests     = 0;
    int n_full_hits    = 0;
    int n_removed      = 0;
    int n_checked      = 0;

    sorted_priority_queue_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Free-running clock.
    initial begin
        forever #(CLK_PER / 2) aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(64'd5_000_000);
        $display("tb: failure");
        $finish;
    end

    // Receiver side: random back-pressure at the configured rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Apply one request to the shadow queue and return what the block must answer.
    function automatic queue_result_t apply_request(logic [2:0] op, logic [7:0] key,
                                                    logic [15:0] tg, logic need_tag);
        queue_result_t res;
        int i;
        int j;
        res = '{status: STAT_NONE, prio: 8'd0, tag: 16'd0, count: 5'd0};
        case (op)
            OP_INSERT: begin
                if (shadow_count >= QDEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    // New entry goes behind every entry that is not greater.
                    for (i = 0; i < shadow_count; i++)
                        if (shadow_prio[i] > key) break;
                    for (j = shadow_count; j > i; j--) begin
                        shadow_prio[j] = shadow_prio[j-1];
                        shadow_tag[j]  = shadow_tag[j-1];
                    end
                    shadow_prio[i] = key;
                    shadow_tag[i]  = tg;
                    shadow_count++;
                    res.status = STAT_OK;
                    res.prio   = key;
                    res.tag    = tg;
                end
            end
            OP_REMOVE: begin
                for (i = 0; i < shadow_count; i++)
                    if (shadow_prio[i] == key && (!need_tag || shadow_tag[i] == tg)) break;
                if (i < shadow_count) begin
                    res.status = STAT_OK;
                    res.prio   = shadow_prio[i];
                    res.tag    = shadow_tag[i];
                    for (j = i; j + 1 < shadow_count; j++) begin
                        shadow_prio[j] = shadow_prio[j+1];
                        shadow_tag[j]  = shadow_tag[j+1];
                    end
                    shadow_count--;
                end
            end
            OP_PEEK, OP_FIND_EQ, OP_FIND_GE: begin
                for (i = 0; i < shadow_count; i++) begin
                    if (op == OP_PEEK) break;
                    if (op == OP_FIND_EQ && shadow_prio[i] == key) break;
                    if (op == OP_FIND_GE && shadow_prio[i] >= key) break;
                end
                if (i < shadow_count) begin
                    res.status = STAT_OK;
                    res.prio   = shadow_prio[i];
                    res.tag    = shadow_tag[i];
                end
            end
            default: ;
        endcase
        res.count = shadow_count[4:0];
        return res;
    endfunction

    // Present one request beat, wait for acceptance, and record its expected result.
    task automatic send_request(logic [2:0] op, logic [7:0] key, logic [15:0] tg,
                                logic need_tag);
        queue_result_t res;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tg, key};
        s_tuser  <= {need_tag, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = apply_request(op, key, tg, need_tag);
        pending_results.push_back(res);
        n_requests++;
        if (res.status == STAT_FULL) n_full_hits++;
        if (op == OP_REMOVE && res.status == STAT_OK) n_removed++;
    endtask

    // Result monitor: every accepted beat must match the oldest expectation.
    always @(posedge aclk) begin
        queue_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: status %0d data %h", m_tuser, m_tdata);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                n_checked++;
                if (m_tuser !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[7:0] !== exp_res.prio) begin
                    $error("result_priority: expected %0d, got %0d",
                           exp_res.prio, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[23:8] !== exp_res.tag) begin
                    $error("result_tag: expected %h, got %h", exp_res.tag, m_tdata[23:8]);
                    fail_count++;
                end
                if (m_tdata[28:24] !== exp_res.count) begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_res.count, m_tdata[28:24]);
                    fail_count++;
                end
            end
        end
    end

    // Peek, find and remove on an empty queue all report not found.
    task automatic test_empty_queue();
        send_request(OP_PEEK, 8'd0, 16'd0, 1'b0);
        send_request(OP_FIND_EQ, 8'd0, 16'hFFFF, 1'b0);
        send_request(OP_FIND_GE, 8'd255, 16'd0, 1'b1);
        send_request(OP_REMOVE, 8'd255, 16'hFFFF, 1'b1);
    endtask

    // Undefined request codes leave the state alone.
    task automatic test_undefined_ops();
        logic [2:0] op;
        for (op = OP_UNDEF_LO; op <= OP_UNDEF_HI && op >= OP_UNDEF_LO; op++)
            send_request(op, 8'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // Fill every slot, with ties and both priority extremes, then insert once more.
    task automatic test_fill_to_full();
        logic [7:0] fill_prio[QDEPTH] = '{8'd255, 8'd0, 8'd7, 8'd7, 8'd7, 8'd128, 8'd3,
                                          8'd200, 8'd7, 8'd1, 8'd254, 8'd64, 8'd9,
                                          8'd7, 8'd100, 8'd50};
        logic [15:0] fill_tag[QDEPTH] = '{16'hFFFF, 16'h0000, 16'h1111, 16'h2222,
                                          16'h3333, 16'hA5A5, 16'h5A5A, 16'h00FF,
                                          16'h4444, 16'hFF00, 16'h0F0F, 16'hF0F0,
                                          16'h1234, 16'h5555, 16'h8000, 16'h0001};
        int k;
        for (k = 0; k < QDEPTH; k++)
            send_request(OP_INSERT, fill_prio[k], fill_tag[k], 1'($urandom));
        send_request(OP_INSERT, 8'd42, 16'hBEEF, 1'b0);
    endtask

    // Searches and removes against the full queue, with and without tag matching.
    task automatic test_search_and_remove();
        send_request(OP_FIND_EQ, 8'd7, 16'd0, 1'b0);
        send_request(OP_FIND_GE, 8'd8, 16'd0, 1'b0);
        send_request(OP_FIND_EQ, 8'd5, 16'd0, 1'b0);
        send_request(OP_REMOVE, 8'd7, 16'h3333, 1'b1);
        send_request(OP_REMOVE, 8'd7, 16'h9999, 1'b1);
        send_request(OP_REMOVE, 8'd7, 16'h9999, 1'b0);
        send_request(OP_REMOVE, 8'd255, 16'd0, 1'b0);
        send_request(OP_PEEK, 8'd0, 16'd0, 1'b0);
    endtask

    // Random traffic; fill and drain bursts alternate so the queue swings
    // between empty and full, and some keys are taken from entries already held.
    task automatic test_random_traffic(int gap_pct, int stall_pct, int n_items);
        int n;
        int r;
        int pick;
        int ins_thr;
        int rem_thr;
        logic [2:0]  op;
        logic [7:0]  key;
        logic [15:0] tg;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < n_items; n++) begin
            ins_thr = ((n / 40) % 2 == 0) ? 62 : 22;
            rem_thr = ins_thr + (((n / 40) % 2 == 0) ? 16 : 48);
            r = $urandom_range(99);
            if (r < ins_thr)
                op = OP_INSERT;
            else if (r < rem_thr)
                op = OP_REMOVE;
            else if (r < 96)
                op = 3'($urandom_range(OP_PEEK, OP_FIND_GE));
            else
                op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
            key = 8'($urandom);
            tg  = 16'($urandom);
            case ($urandom_range(3))
                0: ;
                1: key = 8'($urandom_range(7));
                2: begin
                    if (shadow_count > 0) begin
                        pick = $urandom_range(shadow_count - 1);
                        key  = shadow_prio[pick];
                        if ($urandom_range(1)) tg = shadow_tag[pick];
                    end
                end
                default: key = $urandom_range(1) ? 8'd255 : 8'd0;
            endcase
            send_request(op, key, tg, 1'($urandom));
        end
    endtask

    // Stimulus sequence and end of run.
    initial begin
        int waited;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        recv_stall_pct = 0;
        @(posedge aclk);

        test_empty_queue();
        test_undefined_ops();
        test_fill_to_full();
        test_search_and_remove();

        test_random_traffic(6, 76, 320);
        test_random_traffic(76, 6, 320);
        test_random_traffic(0, 0, 320);

        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 10000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end

        $display("tb: %0d requests sent, %0d results checked", n_requests, n_checked);
        $display("tb: %0d inserts rejected as full, %0d entries removed",
                 n_full_hits, n_removed);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_prefix.sv
rtl/sorted_priority_queue_unit.sv
tb/sv/tb.sv
